// ===== sv/bqaf_pkg.sv =====
// Shared types, widths and codes for the quadratic Bezier flattening block.
`default_nettype none
package bqaf_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_SEGMENTS_DEF = 63;

    localparam int COORD_W    = 32;
    localparam int IDX_W      = 6;
    localparam int WGT_W      = 12;
    localparam int IN_W       = 192;
    localparam int OUT_W      = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = 64;
    localparam int DEN_W      = 32;
    localparam int ROOT_W     = 32;
    localparam int QSAT_W     = 11;
    localparam int CNT_SUM_W  = 12;
    localparam int QSAT       = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SUB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SUB   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] THR_RESET = 32'd16384;
    localparam logic [IDX_W-1:0]      MIN_RESET = 6'd4;
    localparam logic [IDX_W-1:0]      MAX_RESET = 6'd32;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LEG,
        OP_MUL,
        OP_SQRT_GO,
        OP_LEN,
        OP_DIV_GO,
        OP_STORE_U,
        OP_CURV,
        OP_NCALC,
        OP_WEIGHTS,
        OP_STORE_P,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        MS_SQ_A,
        MS_SQ_E,
        MS_W
    } msel_t;

    typedef enum logic [1:0] {
        DS_UNIT,
        DS_QUOT,
        DS_POINT
    } dsel_t;

    typedef struct packed {
        op_t        op;
        logic       leg;
        logic       comp;
        logic       accum;
        msel_t      msel;
        logic [1:0] term;
        dsel_t      dsel;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic len_zero;
        logic thr_zero;
        logic last;
    } status_t;

endpackage
`default_nettype wire

// ===== sv/bqaf_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bqaf_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bqaf_pkg::ACC_W-1:0] num,
    input  wire logic [bqaf_pkg::DEN_W-1:0] den,
    output logic                            busy,
    output logic [bqaf_pkg::ACC_W-1:0]      quo
);
    import bqaf_pkg::*;

    localparam int CW = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W:0]   rem_sh, diff;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};
        quo_next = {quo_reg[ACC_W-2:0], ge};
        rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(ACC_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

// ===== sv/bqaf_sqrt.sv =====
// Integer square root, one root bit per cycle.
`default_nettype none
module bqaf_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bqaf_pkg::ACC_W-1:0] rad,
    output logic                            busy,
    output logic [bqaf_pkg::ROOT_W-1:0]     root
);
    import bqaf_pkg::*;

    localparam int CW    = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 4;

    logic [ACC_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg, rem_sh, trial;
    logic [CW-1:0]     cnt_reg;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[ACC_W-1:ACC_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[ACC_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== sv/bqaf_dp.sv =====
// Datapath: point store, shared multiplier, divider, square root, output register.
`default_nettype none
module bqaf_dp #(
    parameter int FRAC_BITS    = bqaf_pkg::FRAC_BITS_DEF,
    parameter int MAX_SEGMENTS = bqaf_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bqaf_pkg::cmd_t                  cmd,
    output bqaf_pkg::status_t                    status,
    input  wire logic [bqaf_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [bqaf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bqaf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [bqaf_pkg::OUT_W-1:0]           m_tdata,
    output logic                                 m_tlast
);
    import bqaf_pkg::*;

    localparam int UW = FRAC_BITS + 2;
    localparam int EW = UW + 1;

    logic [CFG_DATA_W-1:0]     thr_reg;
    logic [IDX_W-1:0]          min_reg, max_reg;
    logic signed [COORD_W-1:0] p_reg [6];
    logic [30:0]               ax_reg, ay_reg;
    logic                      sx_reg, sy_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [ROOT_W-1:0]         len_reg, curv_reg;
    logic signed [UW-1:0]      ux_reg [2];
    logic signed [UW-1:0]      uy_reg [2];
    logic [IDX_W-1:0]          n_reg, i_reg;
    logic [WGT_W-1:0]          w_reg [3];
    logic [WGT_W-1:0]          den2_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic [IDX_W-1:0]          oi_reg;
    logic                      olast_reg;

    logic signed [32:0]        dx, dy;
    logic [32:0]               mx, my, mx1, my1, mx2, my2;
    logic signed [EW-1:0]      ex, ey;
    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        prod;
    logic [ACC_W-1:0]          acc_mag;
    logic                      div_start, div_busy, sqrt_start, sqrt_busy;
    logic [ACC_W-1:0]          div_num, div_quo;
    logic [DEN_W-1:0]          div_den;
    logic [ROOT_W-1:0]         sqrt_root;
    logic [FRAC_BITS:0]        uq;
    logic signed [UW-1:0]      uval;
    logic                      usign;
    logic [ACC_W-1:0]          quot;
    logic [QSAT_W-1:0]         qsat;
    logic [CNT_SUM_W-1:0]      n_w;
    logic [IDX_W-1:0]          nmi;
    logic [ACC_W-1:0]          pq;
    logic signed [ACC_W-1:0]   pval;

    // Leg vector, magnitudes brought below 2^31
    always_comb
    begin
        if (cmd.leg)
        begin
            dx = $signed({p_reg[4][31], p_reg[4]}) - $signed({p_reg[2][31], p_reg[2]});
            dy = $signed({p_reg[5][31], p_reg[5]}) - $signed({p_reg[3][31], p_reg[3]});
        end
        else
        begin
            dx = $signed({p_reg[2][31], p_reg[2]}) - $signed({p_reg[0][31], p_reg[0]});
            dy = $signed({p_reg[3][31], p_reg[3]}) - $signed({p_reg[1][31], p_reg[1]});
        end
        mx  = dx[32] ? 33'(-dx) : 33'(dx);
        my  = dy[32] ? 33'(-dy) : 33'(dy);
        mx1 = ((mx[32:31] | my[32:31]) != 2'b00) ? (mx >> 1) : mx;
        my1 = ((mx[32:31] | my[32:31]) != 2'b00) ? (my >> 1) : my;
        mx2 = ((mx1[32:31] | my1[32:31]) != 2'b00) ? (mx1 >> 1) : mx1;
        my2 = ((mx1[32:31] | my1[32:31]) != 2'b00) ? (my1 >> 1) : my1;
    end

    always_comb
    begin
        ex = $signed({ux_reg[0][UW-1], ux_reg[0]}) - $signed({ux_reg[1][UW-1], ux_reg[1]});
        ey = $signed({uy_reg[0][UW-1], uy_reg[0]}) - $signed({uy_reg[1][UW-1], uy_reg[1]});
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (cmd.msel)
            MS_SQ_A:
            begin
                mul_a = cmd.comp ? $signed({2'b00, ay_reg}) : $signed({2'b00, ax_reg});
            end
            MS_SQ_E:
            begin
                mul_a = cmd.comp ? 33'(ey) : 33'(ex);
            end
            MS_W:
            begin
                mul_a = $signed({21'd0, w_reg[cmd.term]});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        if (cmd.msel == MS_W)
        begin
            mul_b = 33'(p_reg[{cmd.term[1:0], cmd.comp}]);
        end
        else
        begin
            mul_b = mul_a;
        end
        prod     = mul_a * mul_b;
        acc_next = (cmd.accum ? acc_reg : 64'sd0) + prod[ACC_W-1:0];
    end

    always_comb
    begin
        acc_mag = acc_reg[ACC_W-1] ? 64'(-acc_reg) : 64'(acc_reg);
        unique case (cmd.dsel)
            DS_UNIT:
            begin
                div_num = 64'(cmd.comp ? ay_reg : ax_reg) << FRAC_BITS;
                div_den = len_reg;
            end
            DS_QUOT:
            begin
                div_num = 64'(curv_reg);
                div_den = thr_reg;
            end
            DS_POINT:
            begin
                div_num = acc_mag + 64'(den2_reg >> 1);
                div_den = 32'(den2_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
        div_start  = cmd.op == OP_DIV_GO;
        sqrt_start = cmd.op == OP_SQRT_GO;
    end

    always_comb
    begin
        uq    = div_quo[FRAC_BITS:0];
        usign = cmd.comp ? sy_reg : sx_reg;
        if (status.len_zero)
        begin
            uval = '0;
        end
        else
        begin
            uval = usign ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
        end
        quot = status.thr_zero ? '1 : div_quo;
        qsat = (quot > 64'(QSAT)) ? QSAT_W'(QSAT) : quot[QSAT_W-1:0];
        n_w  = CNT_SUM_W'(min_reg) + CNT_SUM_W'(qsat);
        if (n_w > CNT_SUM_W'(max_reg))
        begin
            n_w = CNT_SUM_W'(max_reg);
        end
        if (n_w > CNT_SUM_W'(MAX_SEGMENTS))
        begin
            n_w = CNT_SUM_W'(MAX_SEGMENTS);
        end
        if (n_w == '0)
        begin
            n_w = CNT_SUM_W'(1);
        end
        nmi  = n_reg - i_reg;
        pq   = div_quo;
        pval = acc_reg[ACC_W-1] ? -$signed(pq) : $signed(pq);
    end

    bqaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    bqaf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (acc_reg),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data;
                REG_MIN_SUB:   min_reg <= cfg_data[IDX_W-1:0];
                REG_MAX_SUB:   max_reg <= cfg_data[IDX_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    p_reg[k] <= s_tdata[COORD_W*k +: COORD_W];
                end
            end
            OP_LEG:
            begin
                ax_reg <= mx2[30:0];
                ay_reg <= my2[30:0];
                sx_reg <= dx[32];
                sy_reg <= dy[32];
            end
            OP_MUL:     acc_reg <= acc_next;
            OP_LEN:     len_reg <= sqrt_root;
            OP_CURV:    curv_reg <= sqrt_root;
            OP_STORE_U:
            begin
                if (cmd.comp)
                begin
                    uy_reg[cmd.leg] <= uval;
                end
                else
                begin
                    ux_reg[cmd.leg] <= uval;
                end
            end
            OP_NCALC:
            begin
                n_reg <= n_w[IDX_W-1:0];
                i_reg <= '0;
            end
            OP_WEIGHTS:
            begin
                w_reg[0] <= WGT_W'(nmi) * WGT_W'(nmi);
                w_reg[1] <= WGT_W'({1'b0, i_reg} * {1'b0, nmi} * 2);
                w_reg[2] <= WGT_W'(i_reg) * WGT_W'(i_reg);
                den2_reg <= WGT_W'(n_reg) * WGT_W'(n_reg);
            end
            OP_STORE_P:
            begin
                if (cmd.comp)
                begin
                    py_reg <= pval[COORD_W-1:0];
                end
                else
                begin
                    px_reg <= pval[COORD_W-1:0];
                end
            end
            OP_EMIT:
            begin
                ox_reg    <= px_reg;
                oy_reg    <= py_reg;
                oi_reg    <= i_reg;
                olast_reg <= status.last;
                i_reg     <= i_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status.div_busy  = div_busy;
        status.sqrt_busy = sqrt_busy;
        status.len_zero  = len_reg == '0;
        status.thr_zero  = thr_reg == '0;
        status.last      = i_reg == n_reg;
    end

    assign m_tdata = {2'b00, oi_reg, oy_reg, ox_reg};
    assign m_tlast = olast_reg;
endmodule
`default_nettype wire

// ===== sv/bqaf_ctrl.sv =====
// Controller: sequences leg normalization, curvature, count and point evaluation.
`default_nettype none
module bqaf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire bqaf_pkg::status_t status,
    output bqaf_pkg::cmd_t         cmd
);
    import bqaf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LEG, S_SQ0, S_SQ1, S_RGO, S_RWAIT, S_LEN, S_DGO, S_DWAIT, S_UST,
        S_CE0, S_CE1, S_CGO, S_CWAIT, S_CURV, S_QGO, S_QWAIT, S_NCALC, S_WTS,
        S_P0, S_P1, S_P2, S_PGO, S_PWAIT, S_PST, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   leg_reg, leg_next, comp_reg, comp_next, valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        leg_next   = leg_reg;
        comp_next  = comp_reg;
        valid_next = valid_reg && !m_tready;
        cmd.op     = OP_NONE;
        cmd.leg    = leg_reg;
        cmd.comp   = comp_reg;
        cmd.accum  = 1'b0;
        cmd.msel   = MS_SQ_A;
        cmd.term   = 2'd0;
        cmd.dsel   = DS_UNIT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    leg_next   = 1'b0;
                    state_next = S_LEG;
                end
            end
            S_LEG:
            begin
                cmd.op     = OP_LEG;
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                cmd.op     = OP_MUL;
                cmd.comp   = 1'b0;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.op     = OP_MUL;
                cmd.comp   = 1'b1;
                cmd.accum  = 1'b1;
                state_next = S_RGO;
            end
            S_RGO:
            begin
                cmd.op     = OP_SQRT_GO;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.op     = OP_LEN;
                comp_next  = 1'b0;
                state_next = S_DGO;
            end
            S_DGO:
            begin
                // zero leg: skip the division, store a zero component
                if (status.len_zero)
                begin
                    state_next = S_UST;
                end
                else
                begin
                    cmd.op     = OP_DIV_GO;
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_UST;
                end
            end
            S_UST:
            begin
                cmd.op = OP_STORE_U;
                if (!comp_reg)
                begin
                    comp_next  = 1'b1;
                    state_next = S_DGO;
                end
                else if (!leg_reg)
                begin
                    leg_next   = 1'b1;
                    state_next = S_LEG;
                end
                else
                begin
                    state_next = S_CE0;
                end
            end
            S_CE0:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_SQ_E;
                cmd.comp   = 1'b0;
                state_next = S_CE1;
            end
            S_CE1:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_SQ_E;
                cmd.comp   = 1'b1;
                cmd.accum  = 1'b1;
                state_next = S_CGO;
            end
            S_CGO:
            begin
                cmd.op     = OP_SQRT_GO;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = S_CURV;
                end
            end
            S_CURV:
            begin
                cmd.op     = OP_CURV;
                state_next = S_QGO;
            end
            S_QGO:
            begin
                if (status.thr_zero)
                begin
                    state_next = S_NCALC;
                end
                else
                begin
                    cmd.op     = OP_DIV_GO;
                    cmd.dsel   = DS_QUOT;
                    state_next = S_QWAIT;
                end
            end
            S_QWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_NCALC;
                end
            end
            S_NCALC:
            begin
                cmd.op     = OP_NCALC;
                state_next = S_WTS;
            end
            S_WTS:
            begin
                cmd.op     = OP_WEIGHTS;
                comp_next  = 1'b0;
                state_next = S_P0;
            end
            S_P0:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_W;
                cmd.term   = 2'd0;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_W;
                cmd.term   = 2'd1;
                cmd.accum  = 1'b1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_W;
                cmd.term   = 2'd2;
                cmd.accum  = 1'b1;
                state_next = S_PGO;
            end
            S_PGO:
            begin
                cmd.op     = OP_DIV_GO;
                cmd.dsel   = DS_POINT;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_PST;
                end
            end
            S_PST:
            begin
                cmd.op = OP_STORE_P;
                if (!comp_reg)
                begin
                    comp_next  = 1'b1;
                    state_next = S_P0;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!valid_reg || m_tready)
                begin
                    cmd.op     = OP_EMIT;
                    valid_next = 1'b1;
                    state_next = status.last ? S_IDLE : S_WTS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            leg_reg   <= 1'b0;
            comp_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            leg_reg   <= leg_next;
            comp_reg  <= comp_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = valid_reg;
endmodule
`default_nettype wire

// ===== sv/bezier_quad_adaptive_flatten.sv =====
// Top level of the quadratic Bezier adaptive flattening block.
`default_nettype none
// One curve beat (start, control, end points, signed fixed point) is taken only while
// the block is idle; it then emits n+1 point beats B(i/n), i = 0..n, the last with tlast.
// Lengths, curvature and point sums run through one shared multiplier, a one-bit-per-cycle
// divider and a one-bit-per-cycle square root. Setup takes 3 roots and up to 5 divisions,
// a division being skipped on a zero leg or a zero threshold; each point then takes two
// divisions, and an output stall holds the block before it emits the next point. The next
// curve beat is taken while the last point still waits in the output register.
module bezier_quad_adaptive_flatten #(
    parameter int FRAC_BITS    = bqaf_pkg::FRAC_BITS_DEF,
    parameter int MAX_SEGMENTS = bqaf_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
    input  wire logic [bqaf_pkg::IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // point_x, point_y, point_index, zero pad
    output logic [bqaf_pkg::OUT_W-1:0]           m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [bqaf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bqaf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bqaf_pkg::*;

    cmd_t    cmd;
    status_t status;

    bqaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bqaf_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a curve beat");

    a_div_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !s_tready)
        else $error("divider running while idle");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.div_busy && status.sqrt_busy))
        else $error("divider and square root running together");
`endif
endmodule
`default_nettype wire
